>>> hdl/ddr_pkg.sv
// Shared constants and field widths for the daylight dimming ramp.
package ddr_pkg;

   // Default number of fraction bits of the brightness level.
   localparam int FRAC_BITS_DEFAULT = 12;

   // Field widths fixed by the interface.
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int RAMP_W    = 11;
   localparam int INDEX_W   = 4;
   localparam int DATA_W    = 11;
   localparam int MINUTES_W = 13;
   localparam int DIFF_W    = 14;

   // Day and hour lengths in minutes.
   localparam logic [MINUTES_W-1:0] DAY_MINUTES  = 13'd1440;
   localparam logic [MINUTES_W-1:0] HOUR_MINUTES = 13'd60;

   // Phase codes of a result.
   localparam logic [1:0] PHASE_OFF     = 2'd0;
   localparam logic [1:0] PHASE_SUNRISE = 2'd1;
   localparam logic [1:0] PHASE_SUNSET  = 2'd2;
   localparam logic [1:0] PHASE_FULL    = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] REG_ON_HOUR    = 4'd0;
   localparam logic [INDEX_W-1:0] REG_CLOSE_HOUR = 4'd1;
   localparam logic [INDEX_W-1:0] REG_SUNRISE    = 4'd2;
   localparam logic [INDEX_W-1:0] REG_SUNSET     = 4'd3;

   // Register values after reset.
   localparam logic [HOUR_W-1:0] ON_HOUR_RESET    = 5'd7;
   localparam logic [HOUR_W-1:0] CLOSE_HOUR_RESET = 5'd19;
   localparam logic [RAMP_W-1:0] SUNRISE_RESET    = 11'd30;
   localparam logic [RAMP_W-1:0] SUNSET_RESET     = 11'd30;

endpackage

>>> hdl/ddr_front.sv
// Entry stage: minute counts, window test, ramp choice and divider operands.
module ddr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [ddr_pkg::HOUR_W-1:0]    hour_now,
   input  logic [ddr_pkg::MINUTE_W-1:0]  minute_now,
   input  logic [ddr_pkg::HOUR_W-1:0]    on_hour,
   input  logic [ddr_pkg::HOUR_W-1:0]    close_hour,
   input  logic [ddr_pkg::RAMP_W-1:0]    sunrise_minutes,
   input  logic [ddr_pkg::RAMP_W-1:0]    sunset_minutes,
   output logic                          down_valid,
   input  logic                          down_ready,
   output logic [ddr_pkg::RAMP_W-1:0]    down_rem,
   output logic [ddr_pkg::RAMP_W-1:0]    down_den,
   output logic [1:0]                    down_phase,
   output logic                          down_light
);

   logic [ddr_pkg::MINUTES_W-1:0] now_w;
   logic [ddr_pkg::MINUTES_W-1:0] on_w;
   logic [ddr_pkg::MINUTES_W-1:0] off_w;
   logic                          lit_w;
   logic signed [ddr_pkg::DIFF_W-1:0] elapsed_raw_w;
   logic signed [ddr_pkg::DIFF_W-1:0] remaining_raw_w;
   logic signed [ddr_pkg::DIFF_W-1:0] elapsed_w;
   logic signed [ddr_pkg::DIFF_W-1:0] remaining_w;
   logic signed [ddr_pkg::DIFF_W-1:0] day_w;
   logic signed [ddr_pkg::DIFF_W-1:0] rise_len_w;
   logic signed [ddr_pkg::DIFF_W-1:0] set_len_w;
   logic                          rise_hit_w;
   logic                          set_hit_w;
   logic                          advance_w;

   logic                          valid_ff;
   logic [ddr_pkg::RAMP_W-1:0]    rem_ff,   rem_in;
   logic [ddr_pkg::RAMP_W-1:0]    den_ff,   den_in;
   logic [1:0]                    phase_ff, phase_in;
   logic                          light_ff, light_in;

   // Minute counts of the sample and of the window edges.
   assign now_w = ddr_pkg::MINUTES_W'(hour_now) * ddr_pkg::HOUR_MINUTES
                  + ddr_pkg::MINUTES_W'(minute_now);
   assign on_w  = ddr_pkg::MINUTES_W'(on_hour) * ddr_pkg::HOUR_MINUTES;
   assign off_w = ddr_pkg::MINUTES_W'(close_hour) * ddr_pkg::HOUR_MINUTES;

   // The window wraps past midnight when it opens after it closes.
   assign lit_w = (on_w <= off_w) ? ((now_w >= on_w) && (now_w < off_w))
                                  : ((now_w >= on_w) || (now_w < off_w));

   // Elapsed and remaining minutes, with one day added when negative.
   assign day_w           = $signed({1'b0, ddr_pkg::DAY_MINUTES});
   assign elapsed_raw_w   = $signed({1'b0, now_w}) - $signed({1'b0, on_w});
   assign remaining_raw_w = $signed({1'b0, off_w}) - $signed({1'b0, now_w});
   assign elapsed_w   = elapsed_raw_w[ddr_pkg::DIFF_W-1] ? elapsed_raw_w + day_w
                                                          : elapsed_raw_w;
   assign remaining_w = remaining_raw_w[ddr_pkg::DIFF_W-1] ? remaining_raw_w + day_w
                                                           : remaining_raw_w;

   // A still negative difference compares below any ramp length.
   assign rise_len_w = $signed({3'b000, sunrise_minutes});
   assign set_len_w  = $signed({3'b000, sunset_minutes});
   assign rise_hit_w = (sunrise_minutes != '0) && (elapsed_w < rise_len_w);
   assign set_hit_w  = (sunset_minutes != '0) && (remaining_w < set_len_w);

   // Operands for the divider chain; non-ramp phases divide zero by one.
   always_comb begin
      light_in = lit_w;
      rem_in   = '0;
      den_in   = ddr_pkg::RAMP_W'(1);
      phase_in = ddr_pkg::PHASE_OFF;
      if (lit_w) begin
         if (rise_hit_w) begin
            phase_in = ddr_pkg::PHASE_SUNRISE;
            den_in   = sunrise_minutes;
            if (elapsed_w > 0) begin
               rem_in = elapsed_w[ddr_pkg::RAMP_W-1:0];
            end
         end else if (set_hit_w) begin
            phase_in = ddr_pkg::PHASE_SUNSET;
            den_in   = sunset_minutes;
            if (remaining_w > 0) begin
               rem_in = remaining_w[ddr_pkg::RAMP_W-1:0];
            end
         end else begin
            phase_in = ddr_pkg::PHASE_FULL;
         end
      end
   end

   // Stage register moves when the next cell can take it.
   assign advance_w = !valid_ff || down_ready;
   assign up_ready  = advance_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance_w) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_w && up_valid) begin
         rem_ff   <= rem_in;
         den_ff   <= den_in;
         phase_ff <= phase_in;
         light_ff <= light_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_den   = den_ff;
   assign down_phase = phase_ff;
   assign down_light = light_ff;

endmodule

>>> hdl/ddr_cell.sv
// One restoring division cell: shifts the remainder and settles one quotient bit.
module ddr_cell #(
   parameter int FRAC_BITS = ddr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic [ddr_pkg::RAMP_W-1:0]  up_rem,
   input  logic [ddr_pkg::RAMP_W-1:0]  up_den,
   input  logic [FRAC_BITS-1:0]        up_quo,
   input  logic [1:0]                  up_phase,
   input  logic                        up_light,
   output logic                        down_valid,
   input  logic                        down_ready,
   output logic [ddr_pkg::RAMP_W-1:0]  down_rem,
   output logic [ddr_pkg::RAMP_W-1:0]  down_den,
   output logic [FRAC_BITS-1:0]        down_quo,
   output logic [1:0]                  down_phase,
   output logic                        down_light
);

   logic [ddr_pkg::RAMP_W:0]    dbl_w;
   logic                        fits_w;
   logic                        advance_w;

   logic                        valid_ff;
   logic [ddr_pkg::RAMP_W-1:0]  rem_ff, rem_in;
   logic [ddr_pkg::RAMP_W-1:0]  den_ff;
   logic [FRAC_BITS-1:0]        quo_ff, quo_in;
   logic [1:0]                  phase_ff;
   logic                        light_ff;

   // Remainder stays below the divisor, so the doubled value fits one more bit.
   assign dbl_w  = {up_rem, 1'b0};
   assign fits_w = dbl_w >= {1'b0, up_den};
   assign rem_in = fits_w ? ddr_pkg::RAMP_W'(dbl_w - {1'b0, up_den})
                          : dbl_w[ddr_pkg::RAMP_W-1:0];
   assign quo_in = {up_quo[FRAC_BITS-2:0], fits_w};

   // Cell register moves when its neighbor can take it.
   assign advance_w = !valid_ff || down_ready;
   assign up_ready  = advance_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance_w) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_w && up_valid) begin
         rem_ff   <= rem_in;
         den_ff   <= up_den;
         quo_ff   <= quo_in;
         phase_ff <= up_phase;
         light_ff <= up_light;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_den   = den_ff;
   assign down_quo   = quo_ff;
   assign down_phase = phase_ff;
   assign down_light = light_ff;

endmodule

>>> hdl/daylight_dimming_ramp_top.sv
// Top level of the daylight dimming ramp: registers, entry stage and divider chain.
//
// Usage: each req_ beat carries a time of day (hour, minute); each rsp_ beat
// returns light_on, dim_level and phase for one request, in request order.
// The csr_ channel writes the opening hour, the closing hour, sunrise_minutes
// and sunset_minutes by index; csr_ready is always high, other indexes are
// ignored. Write registers only while no request is in flight.
// From request beat to response beat the path runs through one entry stage,
// then one restoring division cell per fraction bit, each a register that
// passes its beat to its neighbor.
// Throughput is one beat per cycle while rsp_ready stays high: every register
// takes a new beat in the same cycle that its neighbor takes the old one.
// When the receiver stalls, the last cell holds its result and the stages
// behind it keep filling empty slots, so up to FRAC_BITS + 1 beats are
// held before req_ready drops.
// Reset empties the chain and loads the registers with a 07:00 to 19:00
// window and 30-minute ramps.
module daylight_dimming_ramp_top #(
   parameter int FRAC_BITS = ddr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ddr_pkg::HOUR_W-1:0]     req_hour_now,
   input  logic [ddr_pkg::MINUTE_W-1:0]   req_minute_now,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_light_on,
   output logic [FRAC_BITS:0]             rsp_dim_level,
   output logic [1:0]                     rsp_phase,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ddr_pkg::INDEX_W-1:0]    csr_index,
   input  logic [ddr_pkg::DATA_W-1:0]     csr_data
);

   logic [ddr_pkg::HOUR_W-1:0] on_hour_ff;
   logic [ddr_pkg::HOUR_W-1:0] close_hour_ff;
   logic [ddr_pkg::RAMP_W-1:0] sunrise_ff;
   logic [ddr_pkg::RAMP_W-1:0] sunset_ff;

   logic                       valid_w [FRAC_BITS+1];
   logic                       ready_w [FRAC_BITS+1];
   logic [ddr_pkg::RAMP_W-1:0] rem_w   [FRAC_BITS+1];
   logic [ddr_pkg::RAMP_W-1:0] den_w   [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]       quo_w   [FRAC_BITS+1];
   logic [1:0]                 phase_w [FRAC_BITS+1];
   logic                       light_w [FRAC_BITS+1];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_hour_ff    <= ddr_pkg::ON_HOUR_RESET;
         close_hour_ff <= ddr_pkg::CLOSE_HOUR_RESET;
         sunrise_ff    <= ddr_pkg::SUNRISE_RESET;
         sunset_ff     <= ddr_pkg::SUNSET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ddr_pkg::REG_ON_HOUR:    on_hour_ff    <= csr_data[ddr_pkg::HOUR_W-1:0];
            ddr_pkg::REG_CLOSE_HOUR: close_hour_ff <= csr_data[ddr_pkg::HOUR_W-1:0];
            ddr_pkg::REG_SUNRISE:    sunrise_ff    <= csr_data[ddr_pkg::RAMP_W-1:0];
            ddr_pkg::REG_SUNSET:     sunset_ff     <= csr_data[ddr_pkg::RAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Entry stage feeds slot zero of the chain.
   ddr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (req_valid),
      .up_ready        (req_ready),
      .hour_now        (req_hour_now),
      .minute_now      (req_minute_now),
      .on_hour         (on_hour_ff),
      .close_hour      (close_hour_ff),
      .sunrise_minutes (sunrise_ff),
      .sunset_minutes  (sunset_ff),
      .down_valid      (valid_w[0]),
      .down_ready      (ready_w[0]),
      .down_rem        (rem_w[0]),
      .down_den        (den_w[0]),
      .down_phase      (phase_w[0]),
      .down_light      (light_w[0])
   );

   assign quo_w[0] = '0;

   // One cell per fraction bit, most significant bit first.
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
      ddr_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_w[i]),
         .up_ready   (ready_w[i]),
         .up_rem     (rem_w[i]),
         .up_den     (den_w[i]),
         .up_quo     (quo_w[i]),
         .up_phase   (phase_w[i]),
         .up_light   (light_w[i]),
         .down_valid (valid_w[i+1]),
         .down_ready (ready_w[i+1]),
         .down_rem   (rem_w[i+1]),
         .down_den   (den_w[i+1]),
         .down_quo   (quo_w[i+1]),
         .down_phase (phase_w[i+1]),
         .down_light (light_w[i+1])
      );
   end

   // The last cell's register is the output register.
   assign ready_w[FRAC_BITS] = rsp_ready;
   assign rsp_valid    = valid_w[FRAC_BITS];
   assign rsp_light_on = light_w[FRAC_BITS];
   assign rsp_phase    = phase_w[FRAC_BITS];
   assign rsp_dim_level = (phase_w[FRAC_BITS] == ddr_pkg::PHASE_FULL)
                          ? {1'b1, {FRAC_BITS{1'b0}}}
                          : {1'b0, quo_w[FRAC_BITS]};

   // The light flag and the phase code agree on every result.
   a_light_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_light_on == (rsp_phase != ddr_pkg::PHASE_OFF)))
      else $error("light flag disagrees with phase");

   // A dark result carries no brightness.
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_phase == ddr_pkg::PHASE_OFF)) |-> (rsp_dim_level == '0))
      else $error("off phase with nonzero level");

   // A ramp never reaches full brightness.
   a_ramp_below_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_phase == ddr_pkg::PHASE_SUNRISE) ||
                     (rsp_phase == ddr_pkg::PHASE_SUNSET)))
      |-> !rsp_dim_level[FRAC_BITS])
      else $error("ramp level at or above full");

   // The last cell keeps its remainder below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_w[FRAC_BITS] |-> (rem_w[FRAC_BITS] < den_w[FRAC_BITS]))
      else $error("division remainder not below divisor");

   // A stalled slot behind the output holds its beat.
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_w[FRAC_BITS-1] && !ready_w[FRAC_BITS-1])
      |=> (valid_w[FRAC_BITS-1] && $stable(quo_w[FRAC_BITS-1])))
      else $error("stalled chain slot lost its beat");

endmodule
